// ===== rtl/sjf_pkg.sv =====
// Shared types and constants for the servo jog frame generator.
// No dependencies; imported by sjf_front, sjf_back and the top level.
`default_nettype none

package sjf_pkg;

  // Frame layout
  localparam int unsigned FRAME_LEN   = 6;
  localparam int unsigned SERVO_COUNT = 8;
  localparam int unsigned JOINTS      = 4;
  localparam int unsigned POS_W       = 13;

  localparam logic [7:0] FRAME_START  = 8'h80;
  localparam logic [7:0] CMD_SET_POS  = 8'h04;

  // Byte slots inside one frame
  localparam logic [2:0] SLOT_START = 3'd0;
  localparam logic [2:0] SLOT_DEV   = 3'd1;
  localparam logic [2:0] SLOT_CMD   = 3'd2;
  localparam logic [2:0] SLOT_SERVO = 3'd3;
  localparam logic [2:0] SLOT_POS_H = 3'd4;
  localparam logic [2:0] SLOT_POS_L = 3'd5;

  // One-hot action codes
  localparam logic [13:0] ACT_PUSH   = 14'd2;
  localparam logic [13:0] ACT_PULL   = 14'd4;
  localparam logic [13:0] ACT_LIFT   = 14'd8;
  localparam logic [13:0] ACT_DROP   = 14'd16;
  localparam logic [13:0] ACT_LEFT   = 14'd32;
  localparam logic [13:0] ACT_RIGHT  = 14'd64;
  localparam logic [13:0] ACT_ROT_L  = 14'd128;
  localparam logic [13:0] ACT_ROT_R  = 14'd256;

  // Operation codes
  localparam logic OP_JOG  = 1'b0;
  localparam logic OP_HOME = 1'b1;

  // Register addresses (word index)
  localparam logic [1:0] REG_STEP_SIZE = 2'd0;
  localparam logic [1:0] REG_POWER_THR = 2'd1;
  localparam logic [1:0] REG_DEVICE_ID = 2'd2;

  // Register reset values
  localparam logic [9:0] STEP_SIZE_RST = 10'd50;
  localparam logic [6:0] POWER_THR_RST = 7'd20;
  localparam logic [6:0] DEVICE_ID_RST = 7'd1;

  // Joint limits and reset positions
  localparam logic [POS_W-1:0] JOINT_MIN [JOINTS] = '{13'd1200, 13'd1750, 13'd1200, 13'd800};
  localparam logic [POS_W-1:0] JOINT_MAX [JOINTS] = '{13'd5200, 13'd4400, 13'd4600, 13'd4200};
  localparam logic [POS_W-1:0] JOINT_RST [JOINTS] = '{13'd3250, 13'd3000, 13'd2400, 13'd2600};

  // Center positions for the home sweep
  localparam logic [POS_W-1:0] CENTER_POS [8] = '{
    13'd3250, 13'd3000, 13'd2400, 13'd2600, 13'd1000, 13'd3000, 13'd3000, 13'd3000
  };

  // Command passed from the front end to the frame serializer
  typedef struct packed {
    logic             home;
    logic [1:0]       joint;
    logic [POS_W-1:0] pos;
  } cmd_t;

endpackage

`default_nettype wire

// ===== rtl/sjf_fifo.sv =====
// Small register-based FIFO holding commands between front and back end.
// Depends on nothing but its parameters.
`default_nettype none

module sjf_fifo #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 4
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             push_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  output logic                  full_o,
  input  wire logic             pop_i,
  output logic [WIDTH-1:0]      rdata_o,
  output logic                  empty_o
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == CNT_W'(DEPTH));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign rdata_o = mem_q[rd_ptr_q];

  // Pointer and fill count update
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // Storage, no reset needed
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= wdata_i;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/sjf_front.sv =====
// Front end: accepts input beats, filters and decodes actions, updates
// joint positions and queues frame commands. Depends on sjf_pkg.
`default_nettype none

module sjf_front
  import sjf_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic        op_i,
  input  wire logic [13:0] action_i,
  input  wire logic [6:0]  power_i,
  input  wire logic [9:0]  step_size_i,
  input  wire logic [6:0]  power_thr_i,
  input  wire logic        q_full_i,
  output logic             q_push_o,
  output cmd_t             q_cmd_o
);

  logic [POS_W-1:0] pos_q [JOINTS];
  logic [POS_W-1:0] pos_d [JOINTS];
  logic             accept;
  logic             known;
  logic [1:0]       joint;
  logic             up;
  logic [POS_W-1:0] cur_pos;
  logic [POS_W:0]   pos_up_sum;
  logic [POS_W:0]   min_plus_step;
  logic             can_move;
  logic [POS_W-1:0] new_pos;

  assign in_ready_o = !q_full_i;
  assign accept     = in_valid_i && in_ready_o;

  // Action decode: joint and direction
  always_comb begin
    known = 1'b1;
    joint = 2'd0;
    up    = 1'b0;
    case (action_i)
      ACT_RIGHT: begin joint = 2'd0; up = 1'b1; end
      ACT_LEFT:  begin joint = 2'd0; up = 1'b0; end
      ACT_PULL:  begin joint = 2'd1; up = 1'b1; end
      ACT_PUSH:  begin joint = 2'd1; up = 1'b0; end
      ACT_LIFT:  begin joint = 2'd2; up = 1'b1; end
      ACT_DROP:  begin joint = 2'd2; up = 1'b0; end
      ACT_ROT_R: begin joint = 2'd3; up = 1'b1; end
      ACT_ROT_L: begin joint = 2'd3; up = 1'b0; end
      default:   known = 1'b0;
    endcase
  end

  // Limit check and stepped position
  assign cur_pos       = pos_q[joint];
  assign pos_up_sum    = {1'b0, cur_pos} + (POS_W+1)'(step_size_i);
  assign min_plus_step = {1'b0, JOINT_MIN[joint]} + (POS_W+1)'(step_size_i);
  assign can_move      = up ? (pos_up_sum <= {1'b0, JOINT_MAX[joint]})
                            : ({1'b0, cur_pos} >= min_plus_step);
  always_comb begin
    new_pos = cur_pos;
    if (can_move) begin
      new_pos = up ? pos_up_sum[POS_W-1:0] : cur_pos - POS_W'(step_size_i);
    end
  end

  // Queue a command for every beat that produces a frame
  always_comb begin
    q_push_o      = 1'b0;
    q_cmd_o.home  = 1'b0;
    q_cmd_o.joint = joint;
    q_cmd_o.pos   = new_pos;
    for (int j = 0; j < JOINTS; j++) begin
      pos_d[j] = pos_q[j];
    end
    if (accept) begin
      if (op_i == OP_HOME) begin
        q_push_o     = 1'b1;
        q_cmd_o.home = 1'b1;
      end else if (power_i >= power_thr_i && known) begin
        q_push_o     = 1'b1;
        pos_d[joint] = new_pos;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int j = 0; j < JOINTS; j++) begin
        pos_q[j] <= JOINT_RST[j];
      end
    end else begin
      for (int j = 0; j < JOINTS; j++) begin
        pos_q[j] <= pos_d[j];
      end
    end
  end

`ifndef NO_ASSERTIONS
  // Positions never leave their limits
  a_pos_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pos_q[0] >= JOINT_MIN[0]) && (pos_q[0] <= JOINT_MAX[0]) &&
    (pos_q[1] >= JOINT_MIN[1]) && (pos_q[1] <= JOINT_MAX[1]) &&
    (pos_q[2] >= JOINT_MIN[2]) && (pos_q[2] <= JOINT_MAX[2]) &&
    (pos_q[3] >= JOINT_MIN[3]) && (pos_q[3] <= JOINT_MAX[3]))
    else $error("joint position out of limits");

  // No push into a full queue
  a_no_push_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_push_o |-> !q_full_i)
    else $error("push into full queue");

  // A home beat leaves every position unchanged
  a_home_keeps_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && op_i == OP_HOME) |=>
      ($stable(pos_q[0]) && $stable(pos_q[1]) && $stable(pos_q[2]) && $stable(pos_q[3])))
    else $error("home beat changed a joint position");
`endif

endmodule

`default_nettype wire

// ===== rtl/sjf_back.sv =====
// Back end: serializes queued commands into six-byte servo frames,
// one byte per beat, through a registered output stage. Depends on sjf_pkg.
`default_nettype none

module sjf_back
  import sjf_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       q_empty_i,
  input  wire cmd_t       q_cmd_i,
  output logic            q_pop_o,
  input  wire logic [6:0] device_id_i,
  output logic            out_valid_o,
  input  wire logic       out_ready_i,
  output logic [7:0]      out_byte_o,
  output logic            out_last_o
);

  logic [2:0]       slot_q, slot_d;
  logic [2:0]       servo_q, servo_d;
  logic             valid_q, valid_d;
  logic [7:0]       byte_q, byte_d;
  logic             last_q, last_d;
  logic             advance;
  logic             frame_end;
  logic             sweep_end;
  logic [2:0]       servo_num;
  logic [POS_W-1:0] pos;
  logic [7:0]       next_byte;

  assign advance    = !q_empty_i && (!valid_q || out_ready_i);
  assign frame_end  = (slot_q == SLOT_POS_L);
  assign sweep_end  = !q_cmd_i.home || (servo_q == 3'(SERVO_COUNT - 1));
  assign servo_num  = q_cmd_i.home ? servo_q : {1'b0, q_cmd_i.joint};
  assign pos        = q_cmd_i.home ? CENTER_POS[servo_q] : q_cmd_i.pos;
  assign q_pop_o    = advance && frame_end && sweep_end;

  // Byte for the current frame slot
  always_comb begin
    case (slot_q)
      SLOT_START: next_byte = FRAME_START;
      SLOT_DEV:   next_byte = {1'b0, device_id_i};
      SLOT_CMD:   next_byte = CMD_SET_POS;
      SLOT_SERVO: next_byte = {5'd0, servo_num};
      SLOT_POS_H: next_byte = {2'd0, pos[12:7]};
      SLOT_POS_L: next_byte = {1'b0, pos[6:0]};
      default:    next_byte = 8'd0;
    endcase
  end

  // Slot and servo counters, output register
  always_comb begin
    slot_d  = slot_q;
    servo_d = servo_q;
    valid_d = valid_q;
    byte_d  = byte_q;
    last_d  = last_q;
    if (valid_q && out_ready_i) begin
      valid_d = 1'b0;
    end
    if (advance) begin
      valid_d = 1'b1;
      byte_d  = next_byte;
      last_d  = frame_end && sweep_end;
      if (frame_end) begin
        slot_d  = SLOT_START;
        servo_d = sweep_end ? 3'd0 : servo_q + 3'd1;
      end else begin
        slot_d = slot_q + 3'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slot_q  <= SLOT_START;
      servo_q <= 3'd0;
      valid_q <= 1'b0;
      last_q  <= 1'b0;
    end else begin
      slot_q  <= slot_d;
      servo_q <= servo_d;
      valid_q <= valid_d;
      last_q  <= last_d;
    end
  end

  always_ff @(posedge clk_i) begin
    byte_q <= byte_d;
  end

  assign out_valid_o = valid_q;
  assign out_byte_o  = byte_q;
  assign out_last_o  = last_q;

`ifndef NO_ASSERTIONS
  // Slot counter stays inside the frame
  a_slot_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    slot_q <= SLOT_POS_L)
    else $error("frame slot out of range");

  // Servo counter only runs during a home sweep
  a_servo_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (servo_q != 3'd0) |-> (!q_empty_i && q_cmd_i.home))
    else $error("servo counter active outside home sweep");

  // A frame always begins with the start byte
  a_frame_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (advance && slot_q == SLOT_START) |=> (byte_q == FRAME_START))
    else $error("frame does not begin with start byte");

  // Popping happens only on the last byte of a command
  a_pop_on_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop_o |=> (valid_q && last_q))
    else $error("queue popped without a last byte");
`endif

endmodule

`default_nettype wire

// ===== rtl/servo_jog_frame_generator.sv =====
// Top level of the servo jog frame generator: APB register block, front end,
// command queue and frame serializer. Depends on sjf_pkg, sjf_front, sjf_fifo, sjf_back.
`default_nettype none

// Each input beat on the slave stream is a jog event (tuser = 0) or a home
// request (tuser = 1). A jog event with enough power and a known one-hot
// action steps one of four joints, within its limits, and yields one
// six-byte servo frame: 6 output beats. A home request yields one center
// frame for each of the 8 servos: 48 output beats. Events that are too weak
// or carry an unknown action yield nothing. The frame serializer emits one
// byte per cycle while the output is ready and the queue is not empty; the
// front end takes one beat per cycle while its 4-entry command queue has room,
// and the last byte of each event's output carries tlast. Registers (APB,
// byte address): 0x0 step_size, 0x4 power_threshold, 0x8 device_id.
module servo_jog_frame_generator
  import sjf_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // APB configuration port
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [3:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready,
  // Input stream
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [23:0] s_axis_tdata,   // [13:0] action, [20:14] power, [23:21] zero
  input  wire logic        s_axis_tuser,   // [0] op
  // Output stream
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [7:0]       m_axis_tdata,   // [7:0] tx_byte
  output logic             m_axis_tlast
);

  localparam int unsigned QUEUE_DEPTH = 4;

  logic [9:0] step_size_q;
  logic [6:0] power_thr_q;
  logic [6:0] device_id_q;
  logic       cfg_wr;
  logic [1:0] cfg_idx;

  logic       q_push, q_pop, q_full, q_empty;
  cmd_t       q_wcmd, q_rcmd;

  // Configuration registers
  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign cfg_idx = paddr[3:2];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_size_q <= STEP_SIZE_RST;
      power_thr_q <= POWER_THR_RST;
      device_id_q <= DEVICE_ID_RST;
    end else if (cfg_wr) begin
      case (cfg_idx)
        REG_STEP_SIZE: step_size_q <= pwdata[9:0];
        REG_POWER_THR: power_thr_q <= pwdata[6:0];
        REG_DEVICE_ID: device_id_q <= pwdata[6:0];
        default: ;
      endcase
    end
  end

  // Register readback
  always_comb begin
    case (cfg_idx)
      REG_STEP_SIZE: prdata = {22'd0, step_size_q};
      REG_POWER_THR: prdata = {25'd0, power_thr_q};
      REG_DEVICE_ID: prdata = {25'd0, device_id_q};
      default:       prdata = 32'd0;
    endcase
  end

  sjf_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .op_i        (s_axis_tuser),
    .action_i    (s_axis_tdata[13:0]),
    .power_i     (s_axis_tdata[20:14]),
    .step_size_i (step_size_q),
    .power_thr_i (power_thr_q),
    .q_full_i    (q_full),
    .q_push_o    (q_push),
    .q_cmd_o     (q_wcmd)
  );

  sjf_fifo #(
    .WIDTH ($bits(cmd_t)),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .wdata_i (q_wcmd),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .rdata_o (q_rcmd),
    .empty_o (q_empty)
  );

  sjf_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_empty_i   (q_empty),
    .q_cmd_i     (q_rcmd),
    .q_pop_o     (q_pop),
    .device_id_i (device_id_q),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_byte_o  (m_axis_tdata),
    .out_last_o  (m_axis_tlast)
  );

endmodule

`default_nettype wire
